### hw/rtl/dec96r_pkg.sv
package dec96r_pkg;

   // Operation codes on req_operation
   typedef enum logic [1:0] {
      OP_FLOOR  = 2'd0,
      OP_ROUND  = 2'd1,
      OP_TRUNC  = 2'd2,
      OP_NEGATE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   localparam int WORD_W    = 32;
   localparam int MAG_W     = 3 * WORD_W;
   localparam int SCALE_W   = 5;
   localparam int BYTE_W    = 8;
   localparam int DIGIT_W   = 4;
   localparam int NUM_CELLS = MAG_W / BYTE_W;

   // {rem, byte} / 10 as (v * 3277) >> 15, exact for v < 2560
   localparam int CELL_V_W    = DIGIT_W + BYTE_W;
   localparam int RECIP_W     = 12;
   localparam int RECIP_SHIFT = 15;
   localparam logic [RECIP_W-1:0]  RECIP      = 12'd3277;
   localparam logic [DIGIT_W-1:0]  TEN        = 4'd10;
   localparam logic [DIGIT_W-1:0]  ROUND_DIGIT = 4'd5;

   // Remainder and step token handed from one cell to the next lower one
   typedef struct packed {
      logic                act;
      logic [DIGIT_W-1:0]  rem;
   } link_type;

endpackage

### hw/rtl/decimal96_round_to_integer.sv
// Channel  Direction  Handshake            Word
// req      in         req_valid/req_stall  operation, word0..word2, scale, sign
// rsp      out        rsp_valid/rsp_stall  out_word0..out_word2, out_scale, out_sign
//
// Floor, round and truncate (scale clamped to MAX_SCALE) run one divide-by-ten
// wave per scale digit through a row of 12 byte cells, MSB first, and the
// waves overlap skewed. Negate and scale zero skip the cell row and go
// straight to the output stage. One word is worked on at a time.
// Synchronous reset clears the control state and any pending result.
// A result held in the output register under rsp_stall does not block the next accept.
module decimal96_round_to_integer #(
   parameter int MAX_SCALE = 28
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_operation,
   input  logic [dec96r_pkg::WORD_W-1:0]        req_word0,
   input  logic [dec96r_pkg::WORD_W-1:0]        req_word1,
   input  logic [dec96r_pkg::WORD_W-1:0]        req_word2,
   input  logic [dec96r_pkg::SCALE_W-1:0]       req_scale,
   input  logic                                 req_sign,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [dec96r_pkg::WORD_W-1:0]        rsp_out_word0,
   output logic [dec96r_pkg::WORD_W-1:0]        rsp_out_word1,
   output logic [dec96r_pkg::WORD_W-1:0]        rsp_out_word2,
   output logic [dec96r_pkg::SCALE_W-1:0]       rsp_out_scale,
   output logic                                 rsp_out_sign
);

   localparam int NC      = dec96r_pkg::NUM_CELLS;
   localparam int CNT_RAW = $clog2(MAX_SCALE + NC + 1);
   localparam int CNT_W   = (CNT_RAW > dec96r_pkg::SCALE_W) ? CNT_RAW : dec96r_pkg::SCALE_W;
   localparam int MAG_W   = dec96r_pkg::MAG_W;
   localparam int BW      = dec96r_pkg::BYTE_W;

   dec96r_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]                    count_ff;
   logic [dec96r_pkg::SCALE_W-1:0]      div_scale_ff;   // number of /10 steps
   logic [dec96r_pkg::SCALE_W-1:0]      keep_scale_ff;  // clamped input scale
   dec96r_pkg::op_type                  op_ff;
   logic                                sign_ff;
   logic [dec96r_pkg::DIGIT_W-1:0]      last_ff;        // last dropped digit
   logic                                any_ff;         // some dropped digit nonzero

   logic                                rsp_valid_ff;
   logic [MAG_W-1:0]                    rsp_mag_ff;
   logic [dec96r_pkg::SCALE_W-1:0]      rsp_scale_ff;
   logic                                rsp_sign_ff;

   logic [dec96r_pkg::SCALE_W-1:0]      clamp_scale;
   logic                                accept;
   logic                                out_free;
   logic                                run_act;
   logic                                run_done;
   logic                                finish;
   logic                                bump;
   logic [MAG_W-1:0]                    load_mag;
   logic [MAG_W-1:0]                    mag;
   logic [MAG_W-1:0]                    mag_in;

   dec96r_pkg::link_type                link [NC+1];
   logic [BW-1:0]                       cell_byte [NC];

   // ---------------------------------------------------------------
   // Handshake and sequencing
   // ---------------------------------------------------------------
   always_comb begin
      clamp_scale = (req_scale > dec96r_pkg::SCALE_W'(MAX_SCALE))
                    ? dec96r_pkg::SCALE_W'(MAX_SCALE) : req_scale;
      out_free    = !rsp_valid_ff || !rsp_stall;
      accept      = req_valid && (state_ff == dec96r_pkg::ST_IDLE);
      // the wave for step i enters the top cell at count i
      run_act     = (state_ff == dec96r_pkg::ST_RUN) &&
                    (count_ff < CNT_W'(div_scale_ff));
      // last wave leaves the bottom cell at count div_scale + NC - 1
      run_done    = (count_ff == (CNT_W'(div_scale_ff) + CNT_W'(NC - 1)));
      finish      = 1'b0;
      state_in    = state_ff;
      unique case (state_ff)
         dec96r_pkg::ST_IDLE: begin
            if (req_valid) begin
               if ((clamp_scale == '0) ||
                   (dec96r_pkg::op_type'(req_operation) == dec96r_pkg::OP_NEGATE)) begin
                  state_in = dec96r_pkg::ST_FINISH;
               end else begin
                  state_in = dec96r_pkg::ST_RUN;
               end
            end
         end
         dec96r_pkg::ST_RUN: begin
            if (run_done) begin
               state_in = dec96r_pkg::ST_FINISH;
            end
         end
         dec96r_pkg::ST_FINISH: begin
            if (out_free) begin
               finish   = 1'b1;
               state_in = dec96r_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dec96r_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dec96r_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != dec96r_pkg::ST_IDLE);

   // ---------------------------------------------------------------
   // Word capture and step counter
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= '0;
      end else if (state_ff == dec96r_pkg::ST_RUN) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff         <= dec96r_pkg::op_type'(req_operation);
         sign_ff       <= req_sign;
         keep_scale_ff <= clamp_scale;
         div_scale_ff  <= (dec96r_pkg::op_type'(req_operation) == dec96r_pkg::OP_NEGATE)
                          ? '0 : clamp_scale;
      end
   end

   // dropped digits come out of the bottom cell, one per wave
   always_ff @(posedge clock) begin
      if (accept) begin
         last_ff <= '0;
         any_ff  <= 1'b0;
      end else if (link[NC].act) begin
         last_ff <= link[NC].rem;
         any_ff  <= any_ff || (link[NC].rem != '0);
      end
   end

   // ---------------------------------------------------------------
   // Cell row: cell 0 holds the most significant byte
   // ---------------------------------------------------------------
   assign load_mag     = {req_word2, req_word1, req_word0};
   assign link[0].act  = run_act;
   assign link[0].rem  = '0;

   for (genvar k = 0; k < NC; k++) begin : g_cell
      dec96r_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .load      (accept),
         .load_byte (load_mag[MAG_W-1-k*BW -: BW]),
         .link_in   (link[k]),
         .link_out  (link[k+1]),
         .byte_out  (cell_byte[k])
      );
      assign mag[MAG_W-1-k*BW -: BW] = cell_byte[k];
   end

   // ---------------------------------------------------------------
   // Final increment and output register
   // ---------------------------------------------------------------
   always_comb begin
      bump = ((op_ff == dec96r_pkg::OP_FLOOR) && sign_ff && any_ff) ||
             ((op_ff == dec96r_pkg::OP_ROUND) && (last_ff >= dec96r_pkg::ROUND_DIGIT));
      mag_in = mag + MAG_W'(bump);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_mag_ff <= mag_in;
         if (op_ff == dec96r_pkg::OP_NEGATE) begin
            rsp_scale_ff <= keep_scale_ff;
            rsp_sign_ff  <= !sign_ff;
         end else begin
            rsp_scale_ff <= '0;
            rsp_sign_ff  <= sign_ff;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_word0 = rsp_mag_ff[dec96r_pkg::WORD_W-1:0];
   assign rsp_out_word1 = rsp_mag_ff[2*dec96r_pkg::WORD_W-1:dec96r_pkg::WORD_W];
   assign rsp_out_word2 = rsp_mag_ff[MAG_W-1:2*dec96r_pkg::WORD_W];
   assign rsp_out_scale = rsp_scale_ff;
   assign rsp_out_sign  = rsp_sign_ff;

endmodule

### hw/rtl/dec96r_cell.sv
module dec96r_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  logic [dec96r_pkg::BYTE_W-1:0]     load_byte,
   input  dec96r_pkg::link_type              link_in,
   output dec96r_pkg::link_type              link_out,
   output logic [dec96r_pkg::BYTE_W-1:0]     byte_out
);

   localparam int PROD_W = dec96r_pkg::CELL_V_W + dec96r_pkg::RECIP_W;

   logic [dec96r_pkg::BYTE_W-1:0]   byte_ff;
   logic [dec96r_pkg::DIGIT_W-1:0]  rem_ff;
   logic                            act_ff;

   logic [dec96r_pkg::CELL_V_W-1:0] value;
   logic [PROD_W-1:0]               prod;
   logic [dec96r_pkg::BYTE_W-1:0]   quot_in;
   logic [dec96r_pkg::CELL_V_W-1:0] back;
   logic [dec96r_pkg::DIGIT_W-1:0]  rem_in;

   always_comb begin
      value   = {link_in.rem, byte_ff};
      prod    = PROD_W'(value) * PROD_W'(dec96r_pkg::RECIP);
      quot_in = prod[dec96r_pkg::RECIP_SHIFT +: dec96r_pkg::BYTE_W];
      back    = dec96r_pkg::CELL_V_W'(quot_in) * dec96r_pkg::CELL_V_W'(dec96r_pkg::TEN);
      rem_in  = dec96r_pkg::DIGIT_W'(value - back);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
      end else if (load) begin
         act_ff <= 1'b0;
      end else begin
         act_ff <= link_in.act;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= load_byte;
         rem_ff  <= '0;
      end else if (link_in.act) begin
         byte_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   assign link_out.act = act_ff;
   assign link_out.rem = rem_ff;
   assign byte_out     = byte_ff;

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int MAX_SCALE    = 28;
   localparam int RANDOM_ITEMS = 1830;
   // Extra drain after the last expected result, sized from MAX_SCALE.
   localparam int DRAIN_CYCLES = 2 * (MAX_SCALE + 14);
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int MAG_W        = dec96r_pkg::MAG_W;
   localparam int WORD_W       = dec96r_pkg::WORD_W;
   localparam int SCALE_W      = dec96r_pkg::SCALE_W;

   typedef struct {
      logic [MAG_W-1:0]   mag;
      logic [SCALE_W-1:0] scale;
      logic               sign;
   } dec_value_type;

   // Holds the expected results of accepted request words, oldest first.
   class round_scoreboard_type;
      dec_value_type pending[$];
      int unsigned   errors;

      function new();
         errors = 0;
      endfunction

      // Negate flips sign; others divide by ten per scale step, then round.
      function dec_value_type predict(dec96r_pkg::op_type op, logic [MAG_W-1:0] mag,
                                      logic [SCALE_W-1:0] scale, logic sign);
         dec_value_type      r;
         logic [SCALE_W-1:0] eff;
         logic [3:0]         digit;
         logic               dropped;
         eff     = (scale > MAX_SCALE) ? SCALE_W'(MAX_SCALE) : scale;
         r.mag   = mag;
         r.scale = '0;
         r.sign  = sign;
         digit   = '0;
         dropped = 1'b0;
         if (op == dec96r_pkg::OP_NEGATE) begin
            // sign flips even for zero; scale is the clamped one
            r.sign  = ~sign;
            r.scale = eff;
         end else begin
            for (int i = 0; i < eff; i++) begin
               digit   = 4'(r.mag % MAG_W'(10));
               dropped = dropped | (digit != 0);
               r.mag   = r.mag / MAG_W'(10);
            end
            if (op == dec96r_pkg::OP_FLOOR && sign && dropped) begin
               r.mag = r.mag + 1'b1;
            end
            // only the last dropped digit counts; zero when scale is zero
            if (op == dec96r_pkg::OP_ROUND && digit >= dec96r_pkg::ROUND_DIGIT) begin
               r.mag = r.mag + 1'b1;
            end
         end
         return r;
      endfunction

      function void note_request(dec96r_pkg::op_type op, logic [MAG_W-1:0] mag,
                                 logic [SCALE_W-1:0] scale, logic sign);
         pending.push_back(predict(op, mag, scale, sign));
      endfunction

      function void compare_field(string name, logic [WORD_W-1:0] exp_v,
                                  logic [WORD_W-1:0] act_v);
         if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_result(logic [WORD_W-1:0] w0, logic [WORD_W-1:0] w1,
                                 logic [WORD_W-1:0] w2, logic [SCALE_W-1:0] scale,
                                 logic sign);
         dec_value_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %h_%h_%h s%0d n%0b",
                     $time, w2, w1, w0, scale, sign);
            errors++;
         end else begin
            e = pending.pop_front();
            compare_field("out_word0", e.mag[31:0], w0);
            compare_field("out_word1", e.mag[63:32], w1);
            compare_field("out_word2", e.mag[95:64], w2);
            compare_field("out_scale", WORD_W'(e.scale), WORD_W'(scale));
            compare_field("out_sign", WORD_W'(e.sign), WORD_W'(sign));
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_operation;
   logic [WORD_W-1:0]    req_word0;
   logic [WORD_W-1:0]    req_word1;
   logic [WORD_W-1:0]    req_word2;
   logic [SCALE_W-1:0]   req_scale;
   logic                 req_sign;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [WORD_W-1:0]    rsp_out_word0;
   logic [WORD_W-1:0]    rsp_out_word1;
   logic [WORD_W-1:0]    rsp_out_word2;
   logic [SCALE_W-1:0]   rsp_out_scale;
   logic                 rsp_out_sign;

   round_scoreboard_type board;
   int unsigned          cycle_count;
   logic [7:0]           stall_phase;
   logic [1:0]           stall_mode;

   decimal96_round_to_integer #(
      .MAX_SCALE(MAX_SCALE)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_word0(req_word0),
      .req_word1(req_word1),
      .req_word2(req_word2),
      .req_scale(req_scale),
      .req_sign(req_sign),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_word0(rsp_out_word0),
      .rsp_out_word1(rsp_out_word1),
      .rsp_out_word2(rsp_out_word2),
      .rsp_out_scale(rsp_out_scale),
      .rsp_out_sign(rsp_out_sign)
   );

   always #4 clock = ~clock;

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver stall pattern. A new mode is picked whenever stall_phase wraps:
   // no stall, dense random, sparse random, or long periodic stalls.
   always @(posedge clock) begin
      if (stall_phase == 8'd0) begin
         stall_mode <= 2'($urandom_range(0, 3));
      end
      stall_phase <= stall_phase + 1'b1;
      case (stall_mode)
         2'd0: begin
            rsp_stall <= 1'b0;
         end
         2'd1: begin
            rsp_stall <= ($urandom_range(0, 1) == 0);
         end
         2'd2: begin
            rsp_stall <= ($urandom_range(0, 7) == 0);
         end
         default: begin
            rsp_stall <= (stall_phase[5:0] < 6'd40);
         end
      endcase
   end

   // Result monitor. Sampled in the active region of the edge, so all
   // registered outputs still hold their pre-edge values.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_result(rsp_out_word0, rsp_out_word1, rsp_out_word2,
                            rsp_out_scale, rsp_out_sign);
      end
   end

   function automatic logic [MAG_W-1:0] pow10(int n);
      logic [MAG_W-1:0] p;
      p = MAG_W'(1);
      for (int i = 0; i < n; i++) begin
         p = p * MAG_W'(10);
      end
      return p;
   endfunction

   // Magnitude mix: full random, tiny, 64-bit, near the half-way point,
   // all-ones words, and exact multiples plus one digit.
   function automatic logic [MAG_W-1:0] random_mag(logic [SCALE_W-1:0] scale);
      logic [MAG_W-1:0] unit;
      unit = pow10((scale > MAX_SCALE) ? MAX_SCALE : int'(scale));
      case ($urandom_range(0, 5))
         0: begin
            return {$urandom, $urandom, $urandom};
         end
         1: begin
            return MAG_W'($urandom_range(0, 999));
         end
         2: begin
            return {32'h0, $urandom, $urandom};
         end
         3: begin
            // straddles ...5000 of the dropped digits
            return unit * MAG_W'($urandom_range(0, 1000)) + unit / 2
                   + MAG_W'($urandom_range(0, 2)) - MAG_W'(1);
         end
         4: begin
            return {($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom,
                    ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom,
                    ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom};
         end
         default: begin
            return unit * MAG_W'({$urandom, $urandom})
                   + (unit / 10) * MAG_W'($urandom_range(0, 9));
         end
      endcase
   endfunction

   // Present one request word and hold it until accepted. valid is left
   // high; the caller lowers it through pause() or after the last word.
   task automatic send_word(dec96r_pkg::op_type op, logic [MAG_W-1:0] mag,
                            logic [SCALE_W-1:0] scale, logic sign);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_word0     <= mag[31:0];
      req_word1     <= mag[63:32];
      req_word2     <= mag[95:64];
      req_scale     <= scale;
      req_sign      <= sign;
      do begin
         @(posedge clock);
      end while (req_stall);
      board.note_request(op, mag, scale, sign);
   endtask

   task automatic pause(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   initial begin
      int               sent;
      int               burst;
      logic [SCALE_W-1:0] sc;
      logic [MAG_W-1:0] all_ones;

      board         = new();
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = '0;
      req_word0     = '0;
      req_word1     = '0;
      req_word2     = '0;
      req_scale     = '0;
      req_sign      = 1'b0;
      rsp_stall     = 1'b0;
      cycle_count   = 0;
      stall_phase   = '0;
      stall_mode    = '0;
      all_ones      = '1;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // --- directed words ---
      // zero with every op, negate of zero flips sign
      send_word(dec96r_pkg::OP_FLOOR, '0, 5'd3, 1'b1);
      send_word(dec96r_pkg::OP_ROUND, '0, 5'd3, 1'b0);
      send_word(dec96r_pkg::OP_TRUNC, '0, 5'd0, 1'b1);
      send_word(dec96r_pkg::OP_NEGATE, '0, 5'd0, 1'b0);
      send_word(dec96r_pkg::OP_NEGATE, '0, 5'd7, 1'b1);
      // full magnitude at scale zero: passes through unchanged
      send_word(dec96r_pkg::OP_FLOOR, all_ones, 5'd0, 1'b1);
      send_word(dec96r_pkg::OP_ROUND, all_ones, 5'd0, 1'b0);
      send_word(dec96r_pkg::OP_TRUNC, all_ones, 5'd0, 1'b1);
      // full magnitude at max scale, then saturated scales
      send_word(dec96r_pkg::OP_FLOOR, all_ones, 5'd28, 1'b1);
      send_word(dec96r_pkg::OP_ROUND, all_ones, 5'd28, 1'b0);
      send_word(dec96r_pkg::OP_TRUNC, all_ones, 5'd31, 1'b1);
      send_word(dec96r_pkg::OP_FLOOR, all_ones, 5'd29, 1'b1);
      send_word(dec96r_pkg::OP_NEGATE, all_ones, 5'd31, 1'b0);
      send_word(dec96r_pkg::OP_NEGATE, MAG_W'(123), 5'd29, 1'b1);
      // round half up on magnitude, both signs
      send_word(dec96r_pkg::OP_ROUND, MAG_W'(15), 5'd1, 1'b0);
      send_word(dec96r_pkg::OP_ROUND, MAG_W'(14), 5'd1, 1'b1);
      send_word(dec96r_pkg::OP_ROUND, MAG_W'(25), 5'd1, 1'b1);
      // only the last dropped digit matters for round
      send_word(dec96r_pkg::OP_ROUND, MAG_W'(149), 5'd2, 1'b0);
      send_word(dec96r_pkg::OP_ROUND, MAG_W'(150), 5'd2, 1'b0);
      // floor: an early nonzero digit bumps negatives only
      send_word(dec96r_pkg::OP_FLOOR, MAG_W'(101), 5'd2, 1'b1);
      send_word(dec96r_pkg::OP_FLOOR, MAG_W'(101), 5'd2, 1'b0);
      send_word(dec96r_pkg::OP_FLOOR, MAG_W'(100), 5'd2, 1'b1);
      // increment carry into word1 and into word2
      send_word(dec96r_pkg::OP_ROUND,
                MAG_W'(64'hFFFF_FFFF) * MAG_W'(10) + MAG_W'(9), 5'd1, 1'b0);
      send_word(dec96r_pkg::OP_FLOOR,
                MAG_W'(64'hFFFF_FFFF_FFFF_FFFF) * MAG_W'(10) + MAG_W'(3), 5'd1, 1'b1);

      // --- random words in bursts with random gaps ---
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                             : $urandom_range(1, 12);
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            sc = SCALE_W'($urandom_range(0, 31));
            send_word(dec96r_pkg::op_type'($urandom_range(0, 3)), random_mag(sc), sc,
                      1'($urandom_range(0, 1)));
            sent++;
         end
         pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50));
      end
      req_valid <= 1'b0;

      // drain; the watchdog covers a lost result
      while (board.pending.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
